// ----- design/char_lcd_4bit_command_sequencer_assert.svh -----
// Assertion macros used by the sequencer module
`ifndef CHAR_LCD_4BIT_COMMAND_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_4BIT_COMMAND_SEQUENCER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define CLCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("clcd assertion failed");

// next-cycle implication, disabled while reset is low
`define CLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("clcd assertion failed");

`endif

// ----- design/clcd_pkg.sv -----
package clcd_pkg;

    // column clamp for goto
    localparam int MAX_COLUMN = 39;

    // input actions
    localparam logic [3:0] ACT_INIT    = 4'd0;
    localparam logic [3:0] ACT_CHAR    = 4'd1;
    localparam logic [3:0] ACT_GOTO    = 4'd2;
    localparam logic [3:0] ACT_CLEAR   = 4'd3;
    localparam logic [3:0] ACT_ONOFF   = 4'd4;
    localparam logic [3:0] ACT_CURL    = 4'd5;
    localparam logic [3:0] ACT_CURR    = 4'd6;
    localparam logic [3:0] ACT_SHL     = 4'd7;
    localparam logic [3:0] ACT_SHR     = 4'd8;
    localparam logic [3:0] ACT_BUSY    = 4'd9;
    // internal command kind for glyph load
    localparam logic [3:0] KIND_GLYPH  = 4'd10;

    // result cycle kinds
    localparam logic [2:0] CYC_WAIT    = 3'd0;
    localparam logic [2:0] CYC_STROBE  = 3'd1;
    localparam logic [2:0] CYC_POLL    = 3'd2;
    localparam logic [2:0] CYC_NIBBLE  = 3'd3;
    localparam logic [2:0] CYC_REJECT  = 3'd4;

    // result word patterns held between input and output
    localparam logic [1:0] PAT_SINGLE  = 2'd0;
    localparam logic [1:0] PAT_INIT    = 2'd1;
    localparam logic [1:0] PAT_BYTE    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_POLL_LIMIT = 2'd0;
    localparam logic [1:0] CFG_PU_WAIT    = 2'd1;
    localparam logic [1:0] CFG_STEP_WAIT  = 2'd2;

    localparam logic [16:0] POLL_LIMIT_RST = 17'h10000;
    localparam logic [16:0] POLL_SAT       = 17'h1FFFF;
    localparam logic [7:0]  PU_WAIT_RST    = 8'd50;
    localparam logic [7:0]  STEP_WAIT_RST  = 8'd10;

    // instruction bytes
    localparam logic [7:0] INS_CLEAR   = 8'h01;
    localparam logic [7:0] INS_DISPLAY = 8'h0C;
    localparam logic [7:0] INS_CURL    = 8'h10;
    localparam logic [7:0] INS_CURR    = 8'h14;
    localparam logic [7:0] INS_SHL     = 8'h18;
    localparam logic [7:0] INS_SHR     = 8'h1C;
    localparam logic [7:0] INS_DDRAM   = 8'h80;
    localparam logic [7:0] LINE2_OFS   = 8'h40;
    localparam logic [7:0] INS_CGRAM   = 8'h40;

    // raw power-up strobe nibbles
    localparam logic [3:0] NIB_WAKE    = 4'h3;
    localparam logic [3:0] NIB_4BIT    = 4'h2;

    // post-wake init byte sequence; index past the end repeats the last byte
    function automatic logic [7:0] init_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h28;
            4'd1:    b = 8'h08;
            4'd2:    b = 8'h01;
            4'd3:    b = 8'h06;
            default: b = 8'h0C;
        endcase
        return b;
    endfunction

endpackage

// ----- design/char_lcd_4bit_command_sequencer.sv -----
// Channel   Direction  Handshake           Word
// command   in         i_valid / o_ready   action plus command and busy-sample fields
// result    out        o_valid / i_ready   one bus cycle: kind, rs, nibble, wait, timeout, last
// config    in         i_cfg_we            register index and data, taken at once
//
// Each input word is encoded into a held result pattern of 1 to 9 words.
// Results leave one per cycle while i_ready is high; o_ready rises again as the last result
// is taken, so one-result words go one per cycle, and init holds the port for its 9 results.
// The output stage is the result pattern register, set by the combinational encoder.
// Synchronous active-low reset restores config defaults and clears all but the result payload.
`include "char_lcd_4bit_command_sequencer_assert.svh"

module char_lcd_4bit_command_sequencer
    import clcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_action,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_column,
    input  logic [7:0]  i_line,
    input  logic        i_cursor_on,
    input  logic        i_blink_on,
    input  logic [2:0]  i_glyph_number,
    input  logic [63:0] i_glyph_rows,
    input  logic        i_busy_req,
    input  logic        i_load_glyph,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_cycle_kind,
    output logic        o_register_select,
    output logic [3:0]  o_nibble,
    output logic [7:0]  o_wait_ms,
    output logic        o_timed_out,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data
);

    // configuration
    logic [16:0] r_poll_limit;
    logic [7:0]  r_pu_wait;
    logic [7:0]  r_step_wait;

    // command state
    logic        r_in_prog,   n_in_prog;
    logic [3:0]  r_kind,      n_kind;
    logic [3:0]  r_bi,        n_bi;
    logic [7:0]  r_held,      n_held;
    logic [63:0] r_rows,      n_rows;
    logic [2:0]  r_glyph,     n_glyph;
    logic [16:0] r_pc,        n_pc;

    // result pattern register
    logic        r_busy,      n_busy;
    logic [1:0]  r_pat,       n_pat;
    logic [2:0]  r_skind,     n_skind;
    logic [3:0]  r_idx,       n_idx;
    logic [7:0]  r_byte,      n_byte;
    logic        r_rs,        n_rs;
    logic        r_to,        n_to;
    logic        r_more,      n_more;
    logic [7:0]  r_wpu,       n_wpu;
    logic [7:0]  r_wstep,     n_wstep;

    logic        w_in_acc;
    logic        w_out_acc;
    logic [3:0]  w_len;
    logic        w_last;
    logic [16:0] w_limit;
    logic [16:0] w_pc_inc;
    logic [7:0]  w_cur_byte;
    logic        w_cur_rs;
    logic [4:0]  w_count;
    logic [2:0]  w_row;
    logic [5:0]  w_col;
    logic [6:0]  w_addr;
    logic [3:0]  w_bi_inc;

    // result count of the held pattern
    always_comb begin
        case (r_pat)
            PAT_INIT: w_len = 4'd9;
            PAT_BYTE: w_len = r_more ? 4'd3 : 4'd2;
            default:  w_len = 4'd1;
        endcase
    end

    assign w_last    = (r_idx == (w_len - 4'd1));
    assign o_valid   = r_busy;
    assign w_out_acc = r_busy & i_ready;
    assign o_ready   = !r_busy || (i_ready && w_last);
    assign w_in_acc  = i_valid & o_ready;
    assign o_last    = w_last;

    // current byte of the command in progress
    assign w_row = r_bi[3:1];
    always_comb begin
        if (r_kind == ACT_INIT) begin
            w_cur_byte = init_byte(r_bi);
            w_cur_rs   = 1'b0;
            w_count    = 5'd5;
        end else if (r_kind == KIND_GLYPH) begin
            w_cur_byte = r_bi[0] ? r_rows[{w_row, 3'b000} +: 8]
                                 : (INS_CGRAM | {2'b00, r_glyph, w_row});
            w_cur_rs   = r_bi[0];
            w_count    = 5'd16;
        end else begin
            w_cur_byte = r_held;
            w_cur_rs   = (r_kind == ACT_CHAR);
            w_count    = 5'd1;
        end
    end

    // poll limit, zero acting as one; saturating sample count
    assign w_limit  = (r_poll_limit == 17'd0) ? 17'd1 : r_poll_limit;
    assign w_pc_inc = (r_pc != POLL_SAT) ? (r_pc + 17'd1) : r_pc;
    assign w_bi_inc = r_bi + 4'd1;

    // goto address: clamp column, add second-line offset
    assign w_col  = (i_column > 8'(MAX_COLUMN)) ? 6'(MAX_COLUMN) : i_column[5:0];
    assign w_addr = {1'b0, w_col} + ((i_line != 8'd0) ? LINE2_OFS[6:0] : 7'd0);

    // encoder: next state and result pattern for an accepted word, index advance on a taken result
    always_comb begin
        n_in_prog = r_in_prog;
        n_kind    = r_kind;
        n_bi      = r_bi;
        n_held    = r_held;
        n_rows    = r_rows;
        n_glyph   = r_glyph;
        n_pc      = r_pc;
        n_busy    = r_busy;
        n_pat     = r_pat;
        n_skind   = r_skind;
        n_idx     = r_idx;
        n_byte    = r_byte;
        n_rs      = r_rs;
        n_to      = r_to;
        n_more    = r_more;
        n_wpu     = r_wpu;
        n_wstep   = r_wstep;
        if (w_in_acc) begin
            n_busy  = 1'b1;
            n_idx   = 4'd0;
            n_pat   = PAT_SINGLE;
            n_skind = CYC_REJECT;
            if (r_in_prog) begin
                if (i_action == ACT_BUSY) begin
                    n_pc = w_pc_inc;
                    if (i_busy_req && (w_pc_inc < w_limit)) begin
                        n_skind = CYC_POLL;
                    end else begin
                        n_pat  = PAT_BYTE;
                        n_byte = w_cur_byte;
                        n_rs   = w_cur_rs;
                        n_to   = i_busy_req;
                        n_bi   = w_bi_inc;
                        n_pc   = 17'd0;
                        n_more = (w_bi_inc != 4'd0) && ({1'b0, w_bi_inc} < w_count);
                        if (!n_more) begin
                            n_in_prog = 1'b0;
                        end
                    end
                end
            end else if (i_action <= ACT_SHR) begin
                // start of a new command
                n_in_prog = 1'b1;
                n_kind    = i_action;
                n_bi      = 4'd0;
                n_pc      = 17'd0;
                n_held    = 8'd0;
                n_skind   = CYC_POLL;
                case (i_action)
                    ACT_INIT: begin
                        n_pat   = PAT_INIT;
                        n_wpu   = r_pu_wait;
                        n_wstep = r_step_wait;
                    end
                    ACT_CHAR:  n_held = i_char_code;
                    ACT_GOTO:  n_held = INS_DDRAM | {1'b0, w_addr};
                    ACT_CLEAR: begin
                        if (i_load_glyph) begin
                            n_kind  = KIND_GLYPH;
                            n_glyph = i_glyph_number;
                            n_rows  = i_glyph_rows;
                        end else begin
                            n_held = INS_CLEAR;
                        end
                    end
                    ACT_ONOFF: n_held = INS_DISPLAY | {6'd0, i_cursor_on, i_blink_on};
                    ACT_CURL:  n_held = INS_CURL;
                    ACT_CURR:  n_held = INS_CURR;
                    ACT_SHL:   n_held = INS_SHL;
                    default:   n_held = INS_SHR;
                endcase
            end
        end else if (w_out_acc) begin
            if (w_last) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 4'd1;
            end
        end
    end

    // result word for the current index of the held pattern
    always_comb begin
        o_cycle_kind      = CYC_POLL;
        o_register_select = 1'b0;
        o_nibble          = 4'd0;
        o_wait_ms         = 8'd0;
        o_timed_out       = 1'b0;
        case (r_pat)
            PAT_INIT: begin
                if (r_idx == 4'd8) begin
                    o_cycle_kind = CYC_POLL;
                end else if (!r_idx[0]) begin
                    o_cycle_kind = CYC_WAIT;
                    o_wait_ms    = (r_idx == 4'd0) ? r_wpu : r_wstep;
                end else begin
                    o_cycle_kind = CYC_STROBE;
                    o_nibble     = (r_idx == 4'd7) ? NIB_4BIT : NIB_WAKE;
                end
            end
            PAT_BYTE: begin
                if (r_idx != 4'd2) begin
                    o_cycle_kind      = CYC_NIBBLE;
                    o_register_select = r_rs;
                    o_nibble          = (r_idx == 4'd0) ? r_byte[7:4] : r_byte[3:0];
                    o_timed_out       = r_to;
                end
            end
            default: o_cycle_kind = r_skind;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= POLL_LIMIT_RST;
            r_pu_wait    <= PU_WAIT_RST;
            r_step_wait  <= STEP_WAIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POLL_LIMIT: r_poll_limit <= i_cfg_data;
                CFG_PU_WAIT:    r_pu_wait    <= i_cfg_data[7:0];
                CFG_STEP_WAIT:  r_step_wait  <= i_cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    // control and command state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_prog <= 1'b0;
            r_kind    <= 4'd0;
            r_bi      <= 4'd0;
            r_held    <= 8'd0;
            r_rows    <= 64'd0;
            r_glyph   <= 3'd0;
            r_pc      <= 17'd0;
            r_busy    <= 1'b0;
            r_pat     <= PAT_SINGLE;
            r_idx     <= 4'd0;
            r_more    <= 1'b0;
        end else begin
            r_in_prog <= n_in_prog;
            r_kind    <= n_kind;
            r_bi      <= n_bi;
            r_held    <= n_held;
            r_rows    <= n_rows;
            r_glyph   <= n_glyph;
            r_pc      <= n_pc;
            r_busy    <= n_busy;
            r_pat     <= n_pat;
            r_idx     <= n_idx;
            r_more    <= n_more;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_skind <= n_skind;
        r_byte  <= n_byte;
        r_rs    <= n_rs;
        r_to    <= n_to;
        r_wpu   <= n_wpu;
        r_wstep <= n_wstep;
    end

    // checks
    `CLCD_ASSERT_NOW(a_idx_in_range, i_clk, i_rst_n, r_busy, r_idx < w_len)
    `CLCD_ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, w_in_acc, r_busy && (r_idx == 4'd0))
    `CLCD_ASSERT_NOW(a_end_on_send, i_clk, i_rst_n, $fell(r_in_prog), r_busy && (r_pat == PAT_BYTE))
    `CLCD_ASSERT_NOW(a_timeout_nibble, i_clk, i_rst_n, o_valid && o_timed_out, o_cycle_kind == CYC_NIBBLE)

endmodule
